>>> rtl/tccb_pkg.sv
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared types and constants for the text console character buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

    localparam int ROWS_DEF = 24;
    localparam int COLS_DEF = 32;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;

    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col_arg;
        logic [ROW_W-1:0]  row_arg;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_out_item;

endpackage

>>> rtl/tccb_ram.sv
// ----------------------------------------------------------------------------
// tccb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tccb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/text_console_char_buffer.sv
// ----------------------------------------------------------------------------
// text_console_char_buffer
// Text console character store of ROWS by COLS byte cells with a cursor.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in  (cmd, char, col, row)
//  out      output     o_out_valid / i_out_ready  o_out (cell, cursor row, col)
//
//  One item is worked on at a time. Put and goto need no memory read; a read
//  of a cell on the screen waits on the registered read, and one off the
//  screen gives zero cell data. A scroll fills each cell of the upper ROWS-1
//  rows from the row below by a read and a write, then writes spaces to the
//  bottom row; clear writes every cell in turn, bounded by the single write port
//  of the cell memory. After reset a clearing pass writes spaces; no item is
//  accepted during it. A stalled output holds the next result in the block.
// ----------------------------------------------------------------------------
module text_console_char_buffer #(
    parameter int ROWS = tccb_pkg::ROWS_DEF,
    parameter int COLS = tccb_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tccb_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tccb_pkg::t_out_item o_out
);

    localparam int DEPTH    = ROWS * COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int LAST_SCR = (ROWS - 1) * COLS - 1;

    typedef enum logic [2:0] {
        S_RCLR,
        S_IDLE,
        S_CLR,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_RDWAIT,
        S_EMIT
    } t_state;

    t_state                            r_state, n_state;
    logic [tccb_pkg::ROW_W-1:0]        r_row, n_row;
    logic [tccb_pkg::COL_W-1:0]        r_col, n_col;
    logic [AW-1:0]                     r_ptr, n_ptr;
    logic [tccb_pkg::CHAR_W-1:0]       r_data, n_data;
    logic                              r_out_valid, n_out_valid;
    tccb_pkg::t_out_item               r_out, n_out;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [tccb_pkg::CHAR_W-1:0]       mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic [tccb_pkg::CHAR_W-1:0]       mem_rdata;

    logic                              accept;
    logic                              arg_col_ok;
    logic                              arg_row_ok;
    logic [AW-1:0]                     cur_addr;
    logic [AW-1:0]                     arg_addr;

    tccb_ram #(
        .WIDTH(tccb_pkg::CHAR_W),
        .DEPTH(DEPTH)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign arg_col_ok  = {1'b0, i_in.col_arg} < (tccb_pkg::COL_W + 1)'(COLS);
    assign arg_row_ok  = {1'b0, i_in.row_arg} < (tccb_pkg::ROW_W + 1)'(ROWS);
    assign cur_addr    = AW'(r_row) * AW'(COLS) + AW'(r_col);
    assign arg_addr    = AW'(i_in.row_arg) * AW'(COLS) + AW'(i_in.col_arg);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_ptr       = r_ptr;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = tccb_pkg::SPACE_CODE;
        mem_re      = 1'b0;
        mem_raddr   = r_ptr + AW'(COLS);

        case (r_state)
            S_RCLR, S_CLR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == AW'(DEPTH - 1)) begin
                    n_state = (r_state == S_RCLR) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_data  = '0;
                    n_ptr   = '0;
                    n_state = S_EMIT;
                    case (i_in.cmd)
                        tccb_pkg::CMD_PUT: begin
                            if (i_in.char_code != tccb_pkg::NUL_CODE) begin
                                if (i_in.char_code != tccb_pkg::NEWLINE_CODE) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = cur_addr;
                                    mem_wdata = i_in.char_code;
                                end
                                if (i_in.char_code == tccb_pkg::NEWLINE_CODE ||
                                    r_col >= tccb_pkg::COL_W'(COLS - 1)) begin
                                    n_col = '0;
                                    if (r_row >= tccb_pkg::ROW_W'(ROWS - 1)) begin
                                        n_row   = tccb_pkg::ROW_W'(ROWS - 1);
                                        n_state = S_SCR_RD;
                                    end else begin
                                        n_row = r_row + tccb_pkg::ROW_W'(1);
                                    end
                                end else begin
                                    n_col = r_col + tccb_pkg::COL_W'(1);
                                end
                            end
                        end
                        tccb_pkg::CMD_GOTO: begin
                            if (arg_col_ok) begin
                                n_col = i_in.col_arg;
                            end
                            if (arg_row_ok) begin
                                n_row = i_in.row_arg;
                            end
                        end
                        tccb_pkg::CMD_CLEAR: begin
                            n_state = S_CLR;
                        end
                        tccb_pkg::CMD_READ: begin
                            if (arg_col_ok && arg_row_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = arg_addr;
                                n_state   = S_RDWAIT;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCR_RD: begin
                mem_re  = 1'b1;
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_ptr     = r_ptr + AW'(1);
                n_state   = (r_ptr == AW'(LAST_SCR)) ? S_FILL : S_SCR_RD;
            end
            S_FILL: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == AW'(DEPTH - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_RDWAIT: begin
                n_data  = mem_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_data  = r_data;
                    n_out.cursor_row = r_row;
                    n_out.cursor_col = r_col;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RCLR;
            r_row       <= '0;
            r_col       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < (tccb_pkg::ROW_W + 1)'(ROWS)) &&
        ({1'b0, r_col} < (tccb_pkg::COL_W + 1)'(COLS)))
        else $error("cursor left the screen");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("second item taken while one is in progress");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result appeared without a finished item");

    a_scroll_keeps_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCR_RD || r_state == S_SCR_WR || r_state == S_FILL) |->
        (r_row == tccb_pkg::ROW_W'(ROWS - 1)) && (r_col == '0))
        else $error("cursor not on bottom row during scroll");

endmodule

>>> test/text_console_char_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_buffer_tb
// Checks the text console character buffer against its own console model.
// A short directed sequence covers wrapping, scrolling, newlines, the zero
// byte, gotos and reads out of range, and clear. It is followed by a stretch
// with a stalled receiver, a stretch with no idling, and a long random run of
// text, cursor moves, reads and clears. Every result is compared field by
// field with the predicted one, in order.
// ----------------------------------------------------------------------------
module text_console_char_buffer_tb;

    localparam int ROWS          = tccb_pkg::ROWS_DEF;
    localparam int COLS          = tccb_pkg::COLS_DEF;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_CYCLES  = 20;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    tccb_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tccb_pkg::t_out_item out_item;

    logic [tccb_pkg::CHAR_W-1:0] screen_cells [ROWS*COLS];
    logic [tccb_pkg::ROW_W-1:0]  cur_row;
    logic [tccb_pkg::COL_W-1:0]  cur_col;
    tccb_pkg::t_out_item         console_replies_q [$];

    int  error_count   = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  scroll_count  = 0;
    int  clear_count   = 0;
    bit  tx_steady     = 1'b0;
    bit  rx_steady     = 1'b0;
    bit  rx_hold_req   = 1'b0;

    text_console_char_buffer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < ROWS*COLS; i++) begin
            screen_cells[i] = tccb_pkg::SPACE_CODE;
        end
    endfunction

    function automatic void advance_line();
        if (int'(cur_row) >= ROWS-1) begin
            cur_row = tccb_pkg::ROW_W'(ROWS-1);
            for (int i = 0; i < (ROWS-1)*COLS; i++) begin
                screen_cells[i] = screen_cells[i+COLS];
            end
            for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) begin
                screen_cells[i] = tccb_pkg::SPACE_CODE;
            end
            scroll_count++;
        end else begin
            cur_row = cur_row + tccb_pkg::ROW_W'(1);
        end
        cur_col = '0;
    endfunction

    function automatic tccb_pkg::t_out_item console_predict(input tccb_pkg::t_in_item it);
        tccb_pkg::t_out_item res;
        res = '0;
        case (it.cmd)
            tccb_pkg::CMD_PUT: begin
                if (it.char_code == tccb_pkg::NEWLINE_CODE) begin
                    advance_line();
                end else if (it.char_code != tccb_pkg::NUL_CODE) begin
                    screen_cells[int'(cur_row)*COLS + int'(cur_col)] = it.char_code;
                    if (int'(cur_col) >= COLS-1) begin
                        advance_line();
                    end else begin
                        cur_col = cur_col + tccb_pkg::COL_W'(1);
                    end
                end
            end
            tccb_pkg::CMD_GOTO: begin
                if (int'(it.col_arg) < COLS) begin
                    cur_col = it.col_arg;
                end
                if (int'(it.row_arg) < ROWS) begin
                    cur_row = it.row_arg;
                end
            end
            tccb_pkg::CMD_CLEAR: begin
                blank_screen();
                clear_count++;
            end
            default: begin
                if (int'(it.row_arg) < ROWS && int'(it.col_arg) < COLS) begin
                    res.cell_data = screen_cells[int'(it.row_arg)*COLS + int'(it.col_arg)];
                end
            end
        endcase
        res.cursor_row = cur_row;
        res.cursor_col = cur_col;
        return res;
    endfunction

    function automatic tccb_pkg::t_in_item make_cmd(input tccb_pkg::t_cmd c, input int ch,
                                                    input int col, input int row);
        tccb_pkg::t_in_item it;
        it.cmd       = c;
        it.char_code = ch[tccb_pkg::CHAR_W-1:0];
        it.col_arg   = col[tccb_pkg::COL_W-1:0];
        it.row_arg   = row[tccb_pkg::ROW_W-1:0];
        return it;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input tccb_pkg::t_in_item it);
        int gap;
        gap = (tx_steady || $urandom_range(99) < 60) ? 0 : idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        console_replies_q.push_back(console_predict(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        while (console_replies_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(make_cmd(tccb_pkg::CMD_PUT, 72, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_PUT, 255, 63, 31));
        send_item(make_cmd(tccb_pkg::CMD_PUT, tccb_pkg::NUL_CODE, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, 1, 0));
        send_item(make_cmd(tccb_pkg::CMD_PUT, tccb_pkg::NEWLINE_CODE, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_GOTO, 0, COLS-1, ROWS-1));
        send_item(make_cmd(tccb_pkg::CMD_PUT, 90, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, COLS-1, ROWS-2));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, COLS-1, ROWS-1));
        send_item(make_cmd(tccb_pkg::CMD_PUT, tccb_pkg::NEWLINE_CODE, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, COLS-1, ROWS-3));
        send_item(make_cmd(tccb_pkg::CMD_GOTO, 0, 63, 31));
        send_item(make_cmd(tccb_pkg::CMD_GOTO, 0, COLS+8, 5));
        send_item(make_cmd(tccb_pkg::CMD_GOTO, 0, 7, ROWS+6));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, 0, 31));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, 63, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, COLS, ROWS));
        send_item(make_cmd(tccb_pkg::CMD_CLEAR, 0, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, COLS-1, ROWS-3));
        send_item(make_cmd(tccb_pkg::CMD_GOTO, 0, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_PUT, 97, 0, 0));
        send_item(make_cmd(tccb_pkg::CMD_READ, 0, 0, 0));
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block fills up and holds off its input.
    task automatic test_output_stall();
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 4 == 3) begin
                send_item(make_cmd(tccb_pkg::CMD_READ, 0, $urandom_range(COLS-1),
                                   $urandom_range(ROWS-1)));
            end else begin
                send_item(make_cmd(tccb_pkg::CMD_PUT, $urandom_range(33, 126), 0, 0));
            end
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < 120; i++) begin
            if (i % 5 == 4) begin
                send_item(make_cmd(tccb_pkg::CMD_READ, 0, $urandom_range(COLS-1),
                                   $urandom_range(ROWS-1)));
            end else begin
                send_item(make_cmd(tccb_pkg::CMD_PUT, $urandom_range(32, 126),
                                   $urandom_range(63), $urandom_range(31)));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Lines of text with random content between cursor moves and reads,
    // with a little noise and the odd clear.
    task automatic test_random_text(input int n_items);
        int          done_here;
        int          r;
        int          len;
        int          ch;
        int          col;
        int          row;
        logic [31:0] raw;
        done_here = 0;
        while (done_here < n_items) begin
            r = $urandom_range(99);
            if (r < 55) begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    ch = ($urandom_range(9) == 0) ? $urandom_range(255)
                                                  : $urandom_range(32, 126);
                    send_item(make_cmd(tccb_pkg::CMD_PUT, ch, $urandom_range(63),
                                       $urandom_range(31)));
                end
                done_here += len;
                if ($urandom_range(1) == 1) begin
                    send_item(make_cmd(tccb_pkg::CMD_PUT, tccb_pkg::NEWLINE_CODE,
                                       $urandom_range(63), $urandom_range(31)));
                    done_here++;
                end
            end else if (r < 70) begin
                if ($urandom_range(4) == 0) begin
                    col = $urandom_range(63);
                    row = $urandom_range(31);
                end else begin
                    col = $urandom_range(COLS-1);
                    row = ($urandom_range(3) == 0) ? ROWS-1 : $urandom_range(ROWS-1);
                end
                send_item(make_cmd(tccb_pkg::CMD_GOTO, $urandom_range(255), col, row));
                done_here++;
            end else if (r < 90) begin
                col = ($urandom_range(9) < 7) ? $urandom_range(COLS-1) : $urandom_range(63);
                row = ($urandom_range(9) < 8) ? $urandom_range(ROWS-1) : $urandom_range(31);
                send_item(make_cmd(tccb_pkg::CMD_READ, $urandom_range(255), col, row));
                done_here++;
            end else if (r < 93) begin
                send_item(make_cmd(tccb_pkg::CMD_CLEAR, $urandom_range(255),
                                   $urandom_range(63), $urandom_range(31)));
                done_here++;
            end else begin
                raw = $urandom;
                send_item(tccb_pkg::t_in_item'(raw[$bits(tccb_pkg::t_in_item)-1:0]));
                done_here++;
            end
        end
    endtask

    initial begin
        forever begin
            int rx_stall;
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall    = PRESSURE_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else if (rx_steady || $urandom_range(99) < 70) begin
                out_ready <= 1'b1;
            end else begin
                rx_stall = idle_length() - 1;
                out_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        tccb_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (console_replies_q.size() == 0) begin
                $display("%0t: result with nothing pending, got %h", $time, out_item);
                error_count++;
            end else begin
                want = console_replies_q.pop_front();
                if (out_item.cell_data !== want.cell_data) begin
                    $display("%0t: cell_data expected %0d, got %0d", $time,
                             want.cell_data, out_item.cell_data);
                    error_count++;
                end
                if (out_item.cursor_row !== want.cursor_row) begin
                    $display("%0t: cursor_row expected %0d, got %0d", $time,
                             want.cursor_row, out_item.cursor_row);
                    error_count++;
                end
                if (out_item.cursor_col !== want.cursor_col) begin
                    $display("%0t: cursor_col expected %0d, got %0d", $time,
                             want.cursor_col, out_item.cursor_col);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles, %0d results pending", $time,
                 WATCHDOG_MAX, console_replies_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        blank_screen();
        cur_row = '0;
        cur_col = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_stall();
        test_back_to_back();
        test_random_text(770);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
        $display("The console scrolled %0d times and was cleared %0d times.",
                 scroll_count, clear_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/tccb_pkg.sv
rtl/tccb_ram.sv
rtl/text_console_char_buffer.sv
test/text_console_char_buffer_tb.sv
